@@ rtl/core/rlpr_pkg.sv @@
// Shared constants, command/status types and helpers for the LED pattern renderer.
package rlpr_pkg;

  localparam int TIME_W      = 32;
  localparam int CHAN_W      = 8;
  localparam int PERIOD_W    = 16;
  localparam int GRB_W       = 24;
  localparam int PIX_IDX_W   = 6;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int NUM_W       = 24;
  localparam int DIV_CNT_W   = $clog2(TIME_W + 1);

  localparam int NUM_PIXELS_DEF = 3;

  localparam logic [PERIOD_W-1:0] BREATHE_DEFAULT_MS = 16'd2000;
  localparam logic [PERIOD_W-1:0] BLINK_DEFAULT_MS   = 16'd500;
  localparam logic [CHAN_W-1:0]   FULL_LEVEL         = 8'd255;

  localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOLID   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BREATHE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BLINK   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd4;

  typedef struct packed {
    logic cap;
    logic div_mod;
    logic num_load;
    logic div_lvl;
    logic sq_load;
    logic ease_load;
    logic scale_load;
    logic color_load;
    logic commit;
    logic pix_adv;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic changed;
    logic last_pix;
  } sts_t;

  // floor(x / 255), exact for x up to 65279
  function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

@@ rtl/core/rgb_led_pattern_renderer_unit.sv @@
// Top level of the RGB LED pattern renderer.
// Each time tick is turned into one GRB color (off, solid, blink or breathe)
// and, when it differs from the last frame sent or after any register write,
// the color goes out once per pixel, pixel_index 0 to NUM_PIXELS-1, with
// last_pixel on the final one. Each tick is evaluated in full, then the frame,
// if one is sent, goes out pixel by pixel and holds under output stall; the
// controller then returns to idle before the next tick is taken. The arithmetic
// uses the one radix-2 divider, which runs 32 steps for the period modulo and
// 32 more for the breathe level. No new tick is taken until the frame has fully
// drained.
module rgb_led_pattern_renderer_unit #(
  parameter int NUM_PIXELS = rlpr_pkg::NUM_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rlpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlpr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rlpr_pkg::TIME_W-1:0]     time_ms,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rlpr_pkg::GRB_W-1:0]      pixel_grb,
  output logic [rlpr_pkg::PIX_IDX_W-1:0]  pixel_index,
  output logic                            last_pixel
);
  import rlpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rlpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlpr_dp #(
    .NUM_PIXELS (NUM_PIXELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .time_ms     (time_ms),
    .cmd         (cmd),
    .sts         (sts),
    .pixel_grb   (pixel_grb),
    .pixel_index (pixel_index),
    .last_pixel  (last_pixel)
  );

endmodule

@@ rtl/core/rlpr_ctrl.sv @@
// Sequencing state machine of the LED pattern renderer.
module rlpr_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  rlpr_pkg::sts_t sts,
  output rlpr_pkg::cmd_t cmd
);
  import rlpr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_MOD_WAIT, S_NUM, S_LVL, S_LVL_WAIT,
    S_SQ, S_EASE, S_SCALE, S_COLOR, S_CHECK, S_EMIT
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        cmd.div_mod = 1'b1;
        state_next  = S_MOD_WAIT;
      end
      S_MOD_WAIT: if (!sts.div_busy) state_next = S_NUM;
      S_NUM: begin
        cmd.num_load = 1'b1;
        state_next   = S_LVL;
      end
      S_LVL: begin
        cmd.div_lvl = 1'b1;
        state_next  = S_LVL_WAIT;
      end
      S_LVL_WAIT: if (!sts.div_busy) state_next = S_SQ;
      S_SQ: begin
        cmd.sq_load = 1'b1;
        state_next  = S_EASE;
      end
      S_EASE: begin
        cmd.ease_load = 1'b1;
        state_next    = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_load = 1'b1;
        state_next     = S_COLOR;
      end
      S_COLOR: begin
        cmd.color_load = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (sts.changed) begin
          cmd.commit = 1'b1;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          cmd.pix_adv = 1'b1;
          if (sts.last_pix) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= (state_next == S_EMIT);
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ rtl/core/rlpr_dp.sv @@
// Datapath: config registers, shared divider, easing arithmetic and frame output.
module rlpr_dp #(
  parameter int NUM_PIXELS = rlpr_pkg::NUM_PIXELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rlpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlpr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [rlpr_pkg::TIME_W-1:0]     time_ms,
  input  rlpr_pkg::cmd_t                  cmd,
  output rlpr_pkg::sts_t                  sts,
  output logic [rlpr_pkg::GRB_W-1:0]      pixel_grb,
  output logic [rlpr_pkg::PIX_IDX_W-1:0]  pixel_index,
  output logic                            last_pixel
);
  import rlpr_pkg::*;

  logic [MODE_W-1:0]   mode;
  logic [CHAN_W-1:0]   red, green, blue;
  logic [PERIOD_W-1:0] period;

  logic [TIME_W-1:0]   time_q;
  logic [PERIOD_W-1:0] p, h;

  logic [PERIOD_W-1:0]  dv_rem;
  logic [TIME_W-1:0]    dv_quo;
  logic [PERIOD_W-1:0]  dv_div;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic [PERIOD_W:0]    dv_shift;
  logic                 dv_ge;
  logic [PERIOD_W:0]    dv_diff;

  logic [PERIOD_W-1:0] ph;
  logic [PERIOD_W-1:0] sel;
  logic [NUM_W-1:0]    num;
  logic [CHAN_W-1:0]   level;
  logic [15:0]         sq;
  logic [CHAN_W-1:0]   eased;
  logic [15:0]         pr, pg, pb;
  logic [GRB_W-1:0]    grb;
  logic [GRB_W-1:0]    set_grb;
  logic [GRB_W-1:0]    last_sent;
  logic                have_sent;
  logic [PIX_IDX_W-1:0] pix;

  assign p = (period != '0) ? period
           : ((mode == MODE_BLINK) ? BLINK_DEFAULT_MS : BREATHE_DEFAULT_MS);
  assign h = p >> 1;

  assign dv_shift = {dv_rem, dv_quo[TIME_W-1]};
  assign dv_diff  = dv_shift - {1'b0, dv_div};
  assign dv_ge    = (dv_shift >= {1'b0, dv_div});

  assign sel     = (dv_rem < h) ? dv_rem : (p - dv_rem);
  assign level   = (dv_quo[TIME_W-1:CHAN_W] != '0) ? FULL_LEVEL : dv_quo[CHAN_W-1:0];
  assign set_grb = {green, red, blue};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_BREATHE;
      red       <= 8'd255;
      green     <= 8'd0;
      blue      <= 8'd0;
      period    <= 16'd3000;
      last_sent <= '0;
      have_sent <= 1'b0;
      dv_cnt    <= '0;
      pix       <= '0;
    end else begin
      if (cmd.commit) begin
        last_sent <= grb;
        have_sent <= 1'b1;
        pix       <= '0;
      end
      if (cmd.pix_adv) pix <= pix + PIX_IDX_W'(1);
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MODE: begin
            mode      <= cfg_data[MODE_W-1:0];
            have_sent <= 1'b0;
          end
          REG_RED: begin
            red       <= cfg_data[CHAN_W-1:0];
            have_sent <= 1'b0;
          end
          REG_GREEN: begin
            green     <= cfg_data[CHAN_W-1:0];
            have_sent <= 1'b0;
          end
          REG_BLUE: begin
            blue      <= cfg_data[CHAN_W-1:0];
            have_sent <= 1'b0;
          end
          REG_PERIOD: begin
            period    <= cfg_data[PERIOD_W-1:0];
            have_sent <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.div_mod || cmd.div_lvl) begin
        dv_cnt <= DIV_CNT_W'(TIME_W);
      end else if (dv_cnt != '0) begin
        dv_cnt <= dv_cnt - DIV_CNT_W'(1);
      end
    end
  end

  // divider payload and arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.cap) time_q <= time_ms;
    if (cmd.div_mod) begin
      dv_rem <= '0;
      dv_quo <= time_q;
      dv_div <= p;
    end else if (cmd.div_lvl) begin
      dv_rem <= '0;
      dv_quo <= {{(TIME_W-NUM_W){1'b0}}, num};
      dv_div <= h;
    end else if (dv_cnt != '0) begin
      dv_rem <= dv_ge ? dv_diff[PERIOD_W-1:0] : dv_shift[PERIOD_W-1:0];
      dv_quo <= {dv_quo[TIME_W-2:0], dv_ge};
    end
    if (cmd.num_load) begin
      ph  <= dv_rem;
      num <= NUM_W'(sel) * NUM_W'(FULL_LEVEL);
    end
    if (cmd.sq_load)   sq    <= 16'(level) * 16'(level);
    if (cmd.ease_load) eased <= div255(sq);
    if (cmd.scale_load) begin
      pr <= 16'(red)   * 16'(eased);
      pg <= 16'(green) * 16'(eased);
      pb <= 16'(blue)  * 16'(eased);
    end
    if (cmd.color_load) begin
      case (mode)
        MODE_SOLID:   grb <= set_grb;
        MODE_BLINK:   grb <= (ph < h) ? set_grb : '0;
        MODE_BREATHE: grb <= (h == '0) ? '0 : {div255(pg), div255(pr), div255(pb)};
        default:      grb <= '0;
      endcase
    end
  end

  assign sts.div_busy = (dv_cnt != '0);
  assign sts.changed  = !have_sent || (grb != last_sent);
  assign sts.last_pix = (pix == PIX_IDX_W'(NUM_PIXELS - 1));

  assign pixel_grb   = last_sent;
  assign pixel_index = pix;
  assign last_pixel  = sts.last_pix;

endmodule

@@ rtl/core/rlpr_checker.sv @@
// Port-level checks for the LED pattern renderer, bound to the top level.
module rlpr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rlpr_pkg::GRB_W-1:0]      pixel_grb,
  input logic [rlpr_pkg::PIX_IDX_W-1:0]  pixel_index,
  input logic                            last_pixel
);
  import rlpr_pkg::*;

  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("output request while input side open");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_grb) && $stable(pixel_index))
    else $error("stalled output request changed");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_pixel |=>
      out_valid && pixel_index == PIX_IDX_W'($past(pixel_index) + PIX_IDX_W'(1))
      && $stable(pixel_grb))
    else $error("pixel index did not advance within frame");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_pixel |=> !out_valid)
    else $error("output continued past last pixel");

  a_input_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while evaluating");

endmodule

bind rgb_led_pattern_renderer_unit rlpr_checker u_rlpr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_grb   (pixel_grb),
  .pixel_index (pixel_index),
  .last_pixel  (last_pixel)
);
